// ===== design/btg_pkg.sv =====
// types and constants shared by the button gesture classifier
`timescale 1ns / 1ps

package btg_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned CFG_W    = 16;
   localparam int unsigned BUTTON_W = 3;

   localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd600;
   localparam logic [CFG_W-1:0] TAP_WINDOW_RESET = 16'd300;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_LONG_PRESS = 1'b0,
      CSR_TAP_WINDOW = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      GESTURE_SHORT  = 2'd0,
      GESTURE_DOUBLE = 2'd1,
      GESTURE_TRIPLE = 2'd2,
      GESTURE_LONG   = 2'd3
   } gesture_type;

   // per-button tracking state
   typedef struct packed {
      logic [TIME_W-1:0] press_start;
      logic [TIME_W-1:0] first_tap_time;
      logic [TIME_W-1:0] second_tap_time;
      logic              single_pending;
      logic [TIME_W-1:0] single_deadline;
      logic              double_pending;
      logic [TIME_W-1:0] double_deadline;
   } btn_state_type;

   // outcome of evaluating one beat
   typedef struct packed {
      logic        hit;
      gesture_type gesture;
   } eval_result_type;

endpackage

// ===== design/btg_if.sv =====
// handshake channel interfaces for request and response beats
`timescale 1ns / 1ps

interface btg_req_if;
   import btg_pkg::*;
   logic                valid;
   logic                ready;
   logic [TIME_W-1:0]   now_ms;
   logic [BUTTON_W-1:0] button;
   logic                pressed_edge;
   logic                released_edge;

   modport source (output valid, now_ms, button, pressed_edge, released_edge, input ready);
   modport sink   (input valid, now_ms, button, pressed_edge, released_edge, output ready);
endinterface

interface btg_rsp_if;
   import btg_pkg::*;
   logic                valid;
   logic                ready;
   logic [BUTTON_W-1:0] event_button;
   logic [1:0]          gesture;

   modport source (output valid, event_button, gesture, input ready);
   modport sink   (input valid, event_button, gesture, output ready);
endinterface

// ===== design/btg_eval.sv =====
// combinational evaluation of one beat against one button's state
`timescale 1ns / 1ps

module btg_eval
   import btg_pkg::*;
(
   input  btn_state_type     cur_state,
   input  logic [TIME_W-1:0] now_ms,
   input  logic              pressed_edge,
   input  logic              released_edge,
   input  logic [CFG_W-1:0]  long_press_ms,
   input  logic [CFG_W-1:0]  tap_window_ms,
   output btn_state_type     nxt_state,
   output eval_result_type   result
);

   logic [TIME_W-1:0] held;
   logic [TIME_W-1:0] gap_first;
   logic [TIME_W-1:0] gap_second;
   logic [TIME_W-1:0] window;
   logic [TIME_W-1:0] deadline;
   logic              done;

   assign window = TIME_W'(tap_window_ms);
   assign deadline = now_ms + window;

   always_comb begin
      nxt_state = cur_state;
      result.hit = 1'b0;
      result.gesture = GESTURE_SHORT;
      done = 1'b0;

      if (pressed_edge) begin
         nxt_state.press_start = now_ms;
      end

      held = now_ms - nxt_state.press_start;
      gap_first = now_ms - cur_state.first_tap_time;
      gap_second = now_ms - cur_state.second_tap_time;

      if (released_edge) begin
         if (nxt_state.press_start == '0) begin
            // no recorded press: just note the time
            nxt_state.press_start = now_ms;
            done = 1'b1;
         end else if (held >= TIME_W'(long_press_ms)) begin
            nxt_state.first_tap_time = '0;
            nxt_state.second_tap_time = '0;
            nxt_state.single_pending = 1'b0;
            nxt_state.double_pending = 1'b0;
            result.hit = 1'b1;
            result.gesture = GESTURE_LONG;
            done = 1'b1;
         end else if (cur_state.double_pending && gap_second <= window) begin
            nxt_state.first_tap_time = '0;
            nxt_state.second_tap_time = '0;
            nxt_state.single_pending = 1'b0;
            nxt_state.double_pending = 1'b0;
            result.hit = 1'b1;
            result.gesture = GESTURE_TRIPLE;
            done = 1'b1;
         end else if (gap_first <= window) begin
            nxt_state.first_tap_time = '0;
            nxt_state.single_pending = 1'b0;
            nxt_state.second_tap_time = now_ms;
            nxt_state.double_pending = 1'b1;
            nxt_state.double_deadline = deadline;
         end else begin
            nxt_state.first_tap_time = now_ms;
            nxt_state.single_pending = 1'b1;
            nxt_state.single_deadline = deadline;
         end
      end

      if (!done) begin
         if (nxt_state.single_pending && now_ms >= nxt_state.single_deadline) begin
            nxt_state.single_pending = 1'b0;
            result.hit = 1'b1;
            result.gesture = GESTURE_SHORT;
         end else if (nxt_state.double_pending && now_ms >= nxt_state.double_deadline) begin
            nxt_state.double_pending = 1'b0;
            result.hit = 1'b1;
            result.gesture = GESTURE_DOUBLE;
         end
      end
   end

endmodule

// ===== design/button_tap_gesture_classifier_core.sv =====
// top level of the per-button tap and long press gesture classifier
`timescale 1ns / 1ps

// usage
//  req_chan carries one beat per button observation: a ms timestamp, the button
//  index and its debounced press and release edges; a beat with neither edge
//  just checks that button's pending short and double press deadlines
//  rsp_chan carries at most one gesture beat per request beat: the button and
//  its gesture (short, double, triple or long press)
//  csr_we / csr_index / csr_wdata write the long press and tap window
//  thresholds; write them only while the block is idle
//  a request beat is registered in the input register stage, then evaluated
//  against the button's state, and its gesture is registered in the output
//  register that drives rsp_chan
//  throughput: one request beat per cycle while rsp_chan does not stall, set by
//  the read, evaluate and write back of the per-button state registers
//  reset (synchronous, active high) clears all button state and loads the
//  default thresholds of 600 ms and 300 ms; nothing is pending afterwards
//  when rsp_chan stalls the gesture waits in the output register and the input
//  register holds one more beat, after which req_chan.ready drops

module button_tap_gesture_classifier_core
   import btg_pkg::*;
#(
   parameter int unsigned NUM_BUTTONS = 8
)(
   input  logic             clock,
   input  logic             reset,
   btg_req_if.sink          req_chan,
   btg_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   // only indexes reachable by the 3-bit button field need storage
   localparam int unsigned DEPTH = (NUM_BUTTONS < (1 << BUTTON_W)) ? NUM_BUTTONS
                                                                   : (1 << BUTTON_W);
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration
   logic [CFG_W-1:0] long_press_ff, long_press_in;
   logic [CFG_W-1:0] tap_window_ff, tap_window_in;

   // input register stage
   logic                s1_valid_ff, s1_valid_in;
   logic [TIME_W-1:0]   s1_now_ff;
   logic [BUTTON_W-1:0] s1_button_ff;
   logic                s1_pressed_ff;
   logic                s1_released_ff;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BUTTON_W-1:0] rsp_button_ff;
   gesture_type         rsp_gesture_ff;

   // per-button state
   btn_state_type state_ff [DEPTH];

   logic            out_free;
   logic            advance;
   logic            in_range;
   logic [IDX_W-1:0] idx;
   btn_state_type   cur_state;
   btn_state_type   nxt_state;
   eval_result_type result;

   // config write decode
   always_comb begin
      long_press_in = long_press_ff;
      tap_window_in = tap_window_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LONG_PRESS: long_press_in = csr_wdata;
            CSR_TAP_WINDOW: tap_window_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= LONG_PRESS_RESET;
         tap_window_ff <= TAP_WINDOW_RESET;
      end else begin
         long_press_ff <= long_press_in;
         tap_window_ff <= tap_window_in;
      end
   end

   // handshake: evaluate the held beat whenever the output slot can take it
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || advance;

   // a new beat lands, or the held one stays until it can move on
   assign s1_valid_in = (req_chan.valid && req_chan.ready) || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_now_ff      <= req_chan.now_ms;
         s1_button_ff   <= req_chan.button;
         s1_pressed_ff  <= req_chan.pressed_edge;
         s1_released_ff <= req_chan.released_edge;
      end
   end

   // state lookup for the held beat
   assign in_range = 32'(s1_button_ff) < NUM_BUTTONS;
   assign idx = IDX_W'(s1_button_ff);
   assign cur_state = state_ff[idx];

   btg_eval u_eval (
      .cur_state     (cur_state),
      .now_ms        (s1_now_ff),
      .pressed_edge  (s1_pressed_ff),
      .released_edge (s1_released_ff),
      .long_press_ms (long_press_ff),
      .tap_window_ms (tap_window_ff),
      .nxt_state     (nxt_state),
      .result        (result)
   );

   // write back the updated entry; out of range buttons touch nothing
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            state_ff[i] <= '0;
         end
      end else if (advance && in_range) begin
         state_ff[idx] <= nxt_state;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (advance) begin
         rsp_valid_in = in_range && result.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_button_ff  <= s1_button_ff;
         rsp_gesture_ff <= result.gesture;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.event_button = rsp_button_ff;
   assign rsp_chan.gesture      = rsp_gesture_ff;

   // checks

   // a held beat that cannot move on keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_now_ff) && $stable(s1_button_ff))
      else $error("held request beat changed while stalled");

   // an ignored button never yields a gesture
   assert property (@(posedge clock) disable iff (reset)
      advance && !in_range |=> !rsp_valid_ff)
      else $error("gesture reported for out of range button");

   // a reported short press leaves nothing single-pending for that button
   assert property (@(posedge clock) disable iff (reset)
      advance && in_range && result.hit && result.gesture == GESTURE_SHORT
      |=> !state_ff[$past(idx)].single_pending)
      else $error("single press still pending after report");

   // reset brings the thresholds back to their defaults
   assert property (@(posedge clock)
      $past(reset) |-> long_press_ff == LONG_PRESS_RESET && tap_window_ff == TAP_WINDOW_RESET)
      else $error("thresholds not at defaults after reset");

endmodule
